/* design/msmp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msmp_pkg
// Shared types, widths and constant tables of the servo motion profiler.
// ----------------------------------------------------------------------------
package msmp_pkg;

  localparam int unsigned MAX_SERVOS  = 6;
  localparam int unsigned ID_W        = 3;
  localparam int unsigned ANGLE_W     = 9;
  localparam int unsigned DEG_W       = 8;
  localparam int unsigned PULSE_W     = 12;
  localparam int unsigned SPEED_W     = 12;
  localparam int unsigned MAG_W       = 11;
  localparam int unsigned SMIN_W      = 8;
  localparam int unsigned SMAX_W      = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 12;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned FULL_DEG    = 180;
  // x / 180 == (x >> 2) / 45, the last by reciprocal multiply
  localparam int unsigned DIV_SHIFT   = 24;
  localparam int unsigned DIV_BASE    = FULL_DEG / 4;
  localparam int unsigned DIV_RECIP   = ((1 << DIV_SHIFT) + DIV_BASE - 1) / DIV_BASE;

  localparam logic [MAG_W-1:0]   SPEED_LIMIT = 11'd2047;
  localparam logic [PULSE_W-1:0] PULSE_LIMIT = 12'd4095;

  localparam logic [PULSE_W-1:0]    PULSE_MIN_RST = 12'd150;
  localparam logic [PULSE_W-1:0]    PULSE_MAX_RST = 12'd600;
  localparam logic [SMIN_W-1:0]     SPEED_MIN_RST = 8'd2;
  localparam logic [SMAX_W-1:0]     SPEED_MAX_RST = 10'd32;
  localparam logic [PULSE_W-1:0]    SLOW_DIST_RST = 12'd64;

  localparam logic [DEG_W-1:0] MIN_DEG  [MAX_SERVOS] = '{8'd2, 8'd15, 8'd10, 8'd30,
                                                         8'd10, 8'd45};
  localparam logic [DEG_W-1:0] MAX_DEG  [MAX_SERVOS] = '{8'd178, 8'd165, 8'd180, 8'd170,
                                                         8'd170, 8'd85};
  localparam logic [DEG_W-1:0] PARK_DEG [MAX_SERVOS] = '{8'd90, 8'd20, 8'd10, 8'd50,
                                                         8'd90, 8'd71};
  // park angles mapped with the reset pulse range
  localparam logic [PULSE_W-1:0] PARK_PULSE [MAX_SERVOS] = '{12'd375, 12'd200, 12'd175,
                                                             12'd275, 12'd375, 12'd327};

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_TURN = 2'd2,
    OP_PARK = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PULSE_MIN = 3'd0,
    CFG_PULSE_MAX = 3'd1,
    CFG_SPEED_MIN = 3'd2,
    CFG_SPEED_MAX = 3'd3,
    CFG_SLOW_DIST = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    op_e                       op;
    logic [ID_W-1:0]           id;
    logic signed [ANGLE_W-1:0] ang;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_out_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    logic [SMIN_W-1:0]  speed_min;
    logic [SMAX_W-1:0]  speed_max;
    logic [PULSE_W-1:0] slow_dist;
  } cfg_t;

endpackage
`default_nettype wire

/* design/msmp_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msmp channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface msmp_req_if import msmp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic [ID_W-1:0]           servo_id;
  logic signed [ANGLE_W-1:0] angle_deg;

  modport source (output valid, output req_type, output servo_id, output angle_deg,
                  input ready);
  modport sink   (input valid, input req_type, input servo_id, input angle_deg,
                  output ready);
endinterface

interface msmp_rsp_if import msmp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ID_W-1:0]    servo_index;
  logic [PULSE_W-1:0] pulse_width;
  logic               drive_written;
  logic               last;

  modport source (output valid, output servo_index, output pulse_width,
                  output drive_written, output last, input ready);
  modport sink   (input valid, input servo_index, input pulse_width,
                  input drive_written, input last, output ready);
endinterface

interface msmp_cfg_if import msmp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* design/multi_servo_motion_profiler.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_servo_motion_profiler
// Smooth motion profiler for up to six servos with per-servo angle limits.
// ----------------------------------------------------------------------------
// Channels: req_i takes tick, set, turn and park requests; rsp_o returns one
// beat per servo for every tick, last set on the final servo; cfg_i writes
// the pulse range and speed settings; the user must write them only while
// the block is idle, as the block does not enforce it. Requests go into a
// two-entry queue, so up to two beats are taken while the executor is busy.
// The executor handles one command at a time:
//   tick: per servo, a speed divide step, then update and drive;
//   set: multiply, divide, write; turn: clamp, then as set; park: as set
//   for each servo, on the shared multiply and reciprocal-divide mapping unit.
// Sets and turns for absent servos, and sets outside limits, are dropped.
// Reset restores register defaults and parks every servo, speeds zero.
// A stalled result beat is held; the executor waits on the output register
// and the queue fills, then req_i.ready drops.
// ----------------------------------------------------------------------------
module multi_servo_motion_profiler import msmp_pkg::*; #(
  parameter int unsigned NUM_SERVOS   = 6,
  parameter int unsigned ACCEL_FACTOR = 2
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  msmp_req_if.sink   req_i,
  msmp_rsp_if.source rsp_o,
  msmp_cfg_if.sink   cfg_i
);

  cfg_t       cfg_q;
  logic       q_full;
  logic       push;
  logic       pop;
  cmd_t       cmd;
  queue_out_t q_out;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_min <= PULSE_MIN_RST;
      cfg_q.pulse_max <= PULSE_MAX_RST;
      cfg_q.speed_min <= SPEED_MIN_RST;
      cfg_q.speed_max <= SPEED_MAX_RST;
      cfg_q.slow_dist <= SLOW_DIST_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_PULSE_MIN: cfg_q.pulse_min <= cfg_i.data;
        CFG_PULSE_MAX: cfg_q.pulse_max <= cfg_i.data;
        CFG_SPEED_MIN: cfg_q.speed_min <= cfg_i.data[SMIN_W-1:0];
        CFG_SPEED_MAX: cfg_q.speed_max <= cfg_i.data[SMAX_W-1:0];
        CFG_SLOW_DIST: cfg_q.slow_dist <= cfg_i.data;
        default: ;
      endcase
    end
  end

  msmp_front #(
    .NUM_SERVOS (NUM_SERVOS)
  ) u_front (
    .req_i    (req_i),
    .q_full_i (q_full),
    .push_o   (push),
    .cmd_o    (cmd)
  );

  msmp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .pop_i  (pop),
    .full_o (q_full),
    .q_o    (q_out)
  );

  msmp_back #(
    .NUM_SERVOS   (NUM_SERVOS),
    .ACCEL_FACTOR (ACCEL_FACTOR)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .q_i    (q_out),
    .pop_o  (pop),
    .rsp_o  (rsp_o)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && q_full))
    else $error("command pushed into full queue");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> q_out.valid)
    else $error("queue full but reported empty");

  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.last == (rsp_o.servo_index == ID_W'(NUM_SERVOS - 1))))
    else $error("last flag does not match final servo");

  a_pop_only_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_out.valid)
    else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

/* design/msmp_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msmp_front
// Accepts requests, drops sets and turns that cannot take effect, and pushes
// the rest into the command queue.
// ----------------------------------------------------------------------------
module msmp_front import msmp_pkg::*; #(
  parameter int unsigned NUM_SERVOS = 6
) (
  msmp_req_if.sink req_i,
  input  logic     q_full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  logic            id_ok;
  logic [ID_W-1:0] tab_id;
  logic            in_limits;
  logic            keep;
  op_e             op;

  always_comb begin
    op        = op_e'(req_i.req_type);
    id_ok     = req_i.servo_id < ID_W'(NUM_SERVOS);
    tab_id    = id_ok ? req_i.servo_id : '0;
    in_limits = (req_i.angle_deg >= $signed({1'b0, MIN_DEG[tab_id]})) &&
                (req_i.angle_deg <= $signed({1'b0, MAX_DEG[tab_id]}));
    unique case (op)
      OP_SET:  keep = id_ok && in_limits;
      OP_TURN: keep = id_ok;
      OP_TICK: keep = 1'b1;
      OP_PARK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign req_i.ready = !q_full_i;
  assign push_o      = req_i.valid && !q_full_i && keep;
  assign cmd_o.op    = op;
  assign cmd_o.id    = req_i.servo_id;
  assign cmd_o.ang   = req_i.angle_deg;

endmodule
`default_nettype wire

/* design/msmp_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msmp_queue
// Short command queue between the request front and the execution back.
// ----------------------------------------------------------------------------
module msmp_queue import msmp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  cmd_t       cmd_i,
  input  logic       pop_i,
  output logic       full_o,
  output queue_out_t q_o
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  assign full_o    = cnt_q == CNT_W'(QUEUE_DEPTH);
  assign q_o.valid = cnt_q != '0;
  assign q_o.cmd   = mem_q[rd_q];

endmodule
`default_nettype wire

/* design/msmp_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msmp_back
// Executes queued commands: angle-to-pulse mapping through a shared
// multiply / reciprocal-divide unit, and per-servo motion update on ticks.
// ----------------------------------------------------------------------------
module msmp_back import msmp_pkg::*; #(
  parameter int unsigned NUM_SERVOS   = 6,
  parameter int unsigned ACCEL_FACTOR = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  queue_out_t q_i,
  output logic       pop_o,
  msmp_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int unsigned ACC_K = 13;
  localparam int unsigned ACC_M = ((1 << ACC_K) + ACCEL_FACTOR - 1) / ACCEL_FACTOR;
  localparam int unsigned PROD_W = DEG_W + 1 + PULSE_W + 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLAMP = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_WR    = 3'd4;
  localparam logic [2:0] S_TA    = 3'd5;
  localparam logic [2:0] S_TB    = 3'd6;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SERVOS - 1);

  logic [2:0]                 state_q, state_d;
  logic [IDX_W-1:0]           idx_q, idx_d;
  op_e                        op_q, op_d;
  logic [DEG_W-1:0]           deg_q, deg_d;
  logic signed [ANGLE_W-1:0]  ang_q, ang_d;
  logic signed [PROD_W-1:0]   prod_q;
  logic [PULSE_W-1:0]         quo_q;
  logic                       neg_q;

  logic                       eq_q, rev_q, up_q;
  logic [PULSE_W-1:0]         dist_q;
  logic [MAG_W-1:0]           mag_q, div_q;

  logic                       ov_q;
  logic [IDX_W-1:0]           oidx_q;
  logic [PULSE_W-1:0]         opulse_q;
  logic                       ow_q, olast_q;

  logic [PULSE_W-1:0]         cp_q [NUM_SERVOS];
  logic [PULSE_W-1:0]         tp_q [NUM_SERVOS];
  logic signed [SPEED_W-1:0]  ss_q [NUM_SERVOS];
  logic [DEG_W-1:0]           td_q [NUM_SERVOS];

  // mapping datapath
  logic signed [PULSE_W:0]    span;
  logic signed [PROD_W-1:0]   prod_d;
  logic [PROD_W-2:0]          pmag;
  logic [37:0]                qprod;
  logic signed [PULSE_W:0]    qsigned;
  logic signed [PULSE_W:0]    tp_sum;
  logic signed [DEG_W+1:0]    turn_sum;
  logic signed [DEG_W+1:0]    lo_deg, hi_deg;
  logic [DEG_W-1:0]           clamp_deg;

  // motion datapath, first half
  logic [PULSE_W-1:0]         cur, tgt;
  logic signed [SPEED_W-1:0]  spd_s;
  logic                       a_up;
  logic [MAG_W-1:0]           a_mag;
  logic [31:0]                a_divp;

  // motion datapath, second half
  logic                       out_free;
  logic [MAG_W+1:0]           spd_up, spd_sel;
  logic [MAG_W-1:0]           spd;
  logic [PULSE_W:0]           up_sum;
  logic [PULSE_W-1:0]         npos;
  logic                       w_bit;
  logic                       wr_motion, snap, stop;

  always_comb begin
    span     = $signed({1'b0, cfg_i.pulse_max}) - $signed({1'b0, cfg_i.pulse_min});
    prod_d   = $signed({1'b0, deg_q}) * span;
    pmag     = prod_q[PROD_W-1] ? (PROD_W-1)'(-prod_q) : prod_q[PROD_W-2:0];
    qprod    = 38'(pmag[PROD_W-2:2]) * 38'(DIV_RECIP);
    qsigned  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
    tp_sum   = $signed({1'b0, cfg_i.pulse_min}) + qsigned;
    turn_sum = $signed({2'b00, td_q[idx_q]}) + $signed({ang_q[ANGLE_W-1], ang_q});
    lo_deg   = $signed({2'b00, MIN_DEG[idx_q]});
    hi_deg   = $signed({2'b00, MAX_DEG[idx_q]});
    priority if (turn_sum < lo_deg) begin
      clamp_deg = MIN_DEG[idx_q];
    end else if (turn_sum > hi_deg) begin
      clamp_deg = MAX_DEG[idx_q];
    end else begin
      clamp_deg = turn_sum[DEG_W-1:0];
    end
  end

  always_comb begin
    cur    = cp_q[idx_q];
    tgt    = tp_q[idx_q];
    spd_s  = ss_q[idx_q];
    a_up   = cur < tgt;
    a_mag  = spd_s[SPEED_W-1] ? MAG_W'(-spd_s) : spd_s[MAG_W-1:0];
    a_divp = 32'(a_mag) * 32'(ACC_M);
  end

  always_comb begin
    out_free = !ov_q || rsp_o.ready;
    spd_up   = {2'b00, mag_q} * (MAG_W+2)'(ACCEL_FACTOR);
    snap     = dist_q <= {4'b0000, cfg_i.speed_min};
    stop     = eq_q || rev_q;
    priority if (dist_q <= cfg_i.slow_dist) begin
      spd_sel = (div_q < {3'b000, cfg_i.speed_min}) ? {5'b00000, cfg_i.speed_min}
                                                    : {2'b00, div_q};
    end else if (mag_q < {1'b0, cfg_i.speed_max}) begin
      spd_sel = (mag_q == '0) ? {5'b00000, cfg_i.speed_min} : spd_up;
    end else begin
      spd_sel = {2'b00, mag_q};
    end
    spd    = (spd_sel > {2'b00, SPEED_LIMIT}) ? SPEED_LIMIT : spd_sel[MAG_W-1:0];
    up_sum = {1'b0, cur} + {2'b00, spd};
    if (up_q) begin
      npos = up_sum[PULSE_W] ? PULSE_LIMIT : up_sum[PULSE_W-1:0];
    end else begin
      npos = (cur < {1'b0, spd}) ? '0 : cur - {1'b0, spd};
    end
    w_bit     = !stop;
    wr_motion = (state_q == S_TB) && out_free;
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    op_d    = op_q;
    deg_d   = deg_q;
    ang_d   = ang_q;
    pop_o   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_i.valid) begin
          pop_o = 1'b1;
          op_d  = q_i.cmd.op;
          ang_d = q_i.cmd.ang;
          unique case (q_i.cmd.op)
            OP_TICK: begin
              idx_d   = '0;
              state_d = S_TA;
            end
            OP_SET: begin
              idx_d   = q_i.cmd.id[IDX_W-1:0];
              deg_d   = q_i.cmd.ang[DEG_W-1:0];
              state_d = S_MUL;
            end
            OP_TURN: begin
              idx_d   = q_i.cmd.id[IDX_W-1:0];
              state_d = S_CLAMP;
            end
            OP_PARK: begin
              idx_d   = '0;
              deg_d   = PARK_DEG[0];
              state_d = S_MUL;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_CLAMP: begin
        deg_d   = clamp_deg;
        state_d = S_MUL;
      end
      S_MUL: state_d = S_DIV;
      S_DIV: state_d = S_WR;
      S_WR: begin
        if ((op_q == OP_PARK) && (idx_q != LAST_IDX)) begin
          idx_d   = idx_q + 1'b1;
          deg_d   = PARK_DEG[idx_q + 1'b1];
          state_d = S_MUL;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_TA: state_d = S_TB;
      S_TB: begin
        if (out_free) begin
          if (idx_q == LAST_IDX) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_TA;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      op_q    <= OP_TICK;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      op_q    <= op_d;
      if (wr_motion) begin
        ov_q <= 1'b1;
      end else if (rsp_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    deg_q <= deg_d;
    ang_q <= ang_d;
    if (state_q == S_MUL) begin
      prod_q <= prod_d;
    end
    if (state_q == S_DIV) begin
      quo_q <= qprod[DIV_SHIFT +: PULSE_W];
      neg_q <= prod_q[PROD_W-1];
    end
    if (state_q == S_TA) begin
      eq_q   <= cur == tgt;
      up_q   <= a_up;
      rev_q  <= (spd_s != '0) && (spd_s[SPEED_W-1] == a_up);
      dist_q <= a_up ? tgt - cur : cur - tgt;
      mag_q  <= a_mag;
      div_q  <= a_divp[ACC_K +: MAG_W];
    end
    if (wr_motion) begin
      oidx_q   <= idx_q;
      ow_q     <= w_bit;
      olast_q  <= idx_q == LAST_IDX;
      opulse_q <= stop ? cur : (snap ? tgt : npos);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SERVOS; i++) begin
        cp_q[i] <= PARK_PULSE[i];
        tp_q[i] <= PARK_PULSE[i];
        ss_q[i] <= '0;
        td_q[i] <= PARK_DEG[i];
      end
    end else begin
      if (state_q == S_WR) begin
        tp_q[idx_q] <= tp_sum[PULSE_W-1:0];
        td_q[idx_q] <= deg_q;
      end
      if (wr_motion && !eq_q) begin
        if (rev_q || snap) begin
          ss_q[idx_q] <= '0;
        end else begin
          ss_q[idx_q] <= up_q ? $signed({1'b0, spd}) : -$signed({1'b0, spd});
        end
        if (!rev_q) begin
          cp_q[idx_q] <= snap ? tgt : npos;
        end
      end
    end
  end

  assign rsp_o.valid         = ov_q;
  assign rsp_o.servo_index   = ID_W'(oidx_q);
  assign rsp_o.pulse_width   = opulse_q;
  assign rsp_o.drive_written = ow_q;
  assign rsp_o.last          = olast_q;

endmodule
`default_nettype wire

/* bench/servo_profile_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_profile_checker
// Watches the request, result and register channels of the servo motion
// profiler. It keeps its own copy of the servo positions, speeds and targets,
// predicts one result beat per servo for every tick and compares them in order.
// ----------------------------------------------------------------------------
module servo_profile_checker import msmp_pkg::*; #(
  parameter int unsigned NUM_SERVOS   = 6,
  parameter int unsigned ACCEL_FACTOR = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  msmp_req_if  req_i,
  msmp_rsp_if  rsp_i,
  msmp_cfg_if  cfg_i,
  output int   fail_count_o,
  output int   pending_o
);

  typedef struct packed {
    logic [ID_W-1:0]    servo;
    logic [PULSE_W-1:0] pulse;
    logic               drive;
    logic               last;
  } servo_report_t;

  servo_report_t expected_reports[$];
  cfg_t          settings;
  int            cur_pulse  [MAX_SERVOS];
  int            rate       [MAX_SERVOS];
  int            goal_pulse [MAX_SERVOS];
  int            goal_deg   [MAX_SERVOS];

  function automatic int pulse_of(int deg);
    int span;
    span = int'(settings.pulse_max) - int'(settings.pulse_min);
    return int'(settings.pulse_min) + (deg * span) / int'(FULL_DEG);
  endfunction

  function automatic void aim(int id, int deg);
    if (id >= int'(NUM_SERVOS)) return;
    if (deg < int'(MIN_DEG[id]) || deg > int'(MAX_DEG[id])) return;
    goal_deg[id]   = deg;
    goal_pulse[id] = pulse_of(deg);
  endfunction

  // moves one servo a step toward its goal; returns whether it was driven
  function automatic bit advance_servo(int i);
    int gap;
    int mag;
    int npos;
    int smin;
    int smax;
    bit up;
    smin = int'(settings.speed_min);
    smax = int'(settings.speed_max);
    if (cur_pulse[i] == goal_pulse[i]) return 1'b0;
    up = cur_pulse[i] < goal_pulse[i];
    if (rate[i] != 0 && ((rate[i] > 0) != up)) begin
      rate[i] = 0;
      return 1'b0;
    end
    gap = up ? goal_pulse[i] - cur_pulse[i] : cur_pulse[i] - goal_pulse[i];
    mag = rate[i] < 0 ? -rate[i] : rate[i];
    if (gap <= smin) begin
      cur_pulse[i] = goal_pulse[i];
      rate[i]      = 0;
      return 1'b1;
    end
    if (gap <= int'(settings.slow_dist)) begin
      mag = mag / int'(ACCEL_FACTOR);
      if (mag < smin) mag = smin;
    end else if (mag < smax) begin
      mag = (mag == 0) ? smin : mag * int'(ACCEL_FACTOR);
    end
    if (mag > int'(SPEED_LIMIT)) mag = int'(SPEED_LIMIT);
    rate[i] = up ? mag : -mag;
    npos = cur_pulse[i] + rate[i];
    if (npos < 0) npos = 0;
    if (npos > int'(PULSE_LIMIT)) npos = int'(PULSE_LIMIT);
    cur_pulse[i] = npos;
    return 1'b1;
  endfunction

  function automatic void reset_profile();
    settings = '{pulse_min: PULSE_MIN_RST, pulse_max: PULSE_MAX_RST,
                 speed_min: SPEED_MIN_RST, speed_max: SPEED_MAX_RST,
                 slow_dist: SLOW_DIST_RST};
    for (int i = 0; i < int'(MAX_SERVOS); i++) begin
      goal_deg[i]   = int'(PARK_DEG[i]);
      goal_pulse[i] = pulse_of(goal_deg[i]);
      cur_pulse[i]  = goal_pulse[i];
      rate[i]       = 0;
    end
    expected_reports.delete();
  endfunction

  function automatic void check_field(string name, logic [PULSE_W-1:0] want,
                                      logic [PULSE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    servo_report_t got;
    servo_report_t want;
    int id;
    int ang;
    int deg;
    if (!rst_ni) begin
      reset_profile();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_idx_e'(cfg_i.index))
          CFG_PULSE_MIN: settings.pulse_min = cfg_i.data;
          CFG_PULSE_MAX: settings.pulse_max = cfg_i.data;
          CFG_SPEED_MIN: settings.speed_min = cfg_i.data[SMIN_W-1:0];
          CFG_SPEED_MAX: settings.speed_max = cfg_i.data[SMAX_W-1:0];
          CFG_SLOW_DIST: settings.slow_dist = cfg_i.data;
          default: ;
        endcase
      end

      if (rsp_i.valid && rsp_i.ready) begin
        got = '{servo: rsp_i.servo_index, pulse: rsp_i.pulse_width,
                drive: rsp_i.drive_written, last: rsp_i.last};
        if (expected_reports.size() == 0) begin
          $error("unexpected result beat: servo_index %0d pulse_width %0d",
                 got.servo, got.pulse);
          fail_count_o++;
        end else begin
          want = expected_reports.pop_front();
          check_field("servo_index", PULSE_W'(want.servo), PULSE_W'(got.servo));
          check_field("pulse_width", want.pulse, got.pulse);
          check_field("drive_written", PULSE_W'(want.drive), PULSE_W'(got.drive));
          check_field("last", PULSE_W'(want.last), PULSE_W'(got.last));
        end
      end

      if (req_i.valid && req_i.ready) begin
        id  = int'(req_i.servo_id);
        ang = int'(req_i.angle_deg);
        case (op_e'(req_i.req_type))
          OP_SET: aim(id, ang);
          OP_TURN: begin
            if (id < int'(NUM_SERVOS)) begin
              deg = goal_deg[id] + ang;
              if (deg < int'(MIN_DEG[id])) deg = int'(MIN_DEG[id]);
              else if (deg > int'(MAX_DEG[id])) deg = int'(MAX_DEG[id]);
              aim(id, deg);
            end
          end
          OP_PARK: begin
            for (int i = 0; i < int'(NUM_SERVOS); i++) aim(i, int'(PARK_DEG[i]));
          end
          OP_TICK: begin
            for (int i = 0; i < int'(NUM_SERVOS); i++) begin
              want.drive = advance_servo(i);
              want.servo = ID_W'(i);
              want.pulse = PULSE_W'(cur_pulse[i]);
              want.last  = (i == int'(NUM_SERVOS) - 1);
              expected_reports.push_back(want);
            end
          end
          default: ;
        endcase
      end
      pending_o = expected_reports.size();
    end
  end

endmodule

/* bench/multi_servo_motion_profiler_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_servo_motion_profiler_tb
// Drives ticks, absolute sets, relative turns and park requests into the
// profiler under several register settings and handshake pressure patterns.
// A checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module multi_servo_motion_profiler_tb;
  import msmp_pkg::*;

  localparam int ITEMS_PER_PHASE = 55;
  localparam int QUIET_CYCLES    = 100;
  localparam int CYCLE_LIMIT     = 500000;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   idle_pct    = 0;
  int   stall_pct   = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;

  always #5 clk_i = ~clk_i;

  msmp_req_if req_ch ();
  msmp_rsp_if rsp_ch ();
  msmp_cfg_if cfg_ch ();

  multi_servo_motion_profiler u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  servo_profile_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .rsp_i        (rsp_ch),
    .cfg_i        (cfg_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_cmd(op_e op, logic [ID_W-1:0] id, logic signed [ANGLE_W-1:0] ang);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= op;
    req_ch.servo_id  <= id;
    req_ch.angle_deg <= ang;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // waits out every result and whatever the command queue still holds
  task automatic drain();
    req_ch.valid <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(logic [PULSE_W-1:0] pmin, logic [PULSE_W-1:0] pmax,
                              logic [SMIN_W-1:0] smin, logic [SMAX_W-1:0] smax,
                              logic [PULSE_W-1:0] sdist);
    cfg_idx_e idx;
    logic [CFG_DATA_W-1:0] value;
    idx = CFG_PULSE_MIN;
    repeat (idx.num()) begin
      case (idx)
        CFG_PULSE_MIN: value = pmin;
        CFG_PULSE_MAX: value = pmax;
        CFG_SPEED_MIN: value = CFG_DATA_W'(smin);
        CFG_SPEED_MAX: value = CFG_DATA_W'(smax);
        default:       value = sdist;
      endcase
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= idx;
      cfg_ch.data  <= value;
      do @(posedge clk_i); while (!cfg_ch.ready);
      idx = idx.next();
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic random_cmd();
    int pick;
    int sid;
    int lim;
    logic signed [ANGLE_W-1:0] ang;
    pick = $urandom_range(99);
    sid  = ($urandom_range(9) == 0) ? $urandom_range(7, 6) : $urandom_range(5, 0);
    lim  = sid % 6;
    if (pick < 45) begin
      send_cmd(OP_TICK, ID_W'($urandom), ANGLE_W'($urandom));
    end else if (pick < 70) begin
      if ($urandom_range(4) == 0) ang = ANGLE_W'($urandom);
      else ang = ANGLE_W'($urandom_range(int'(MAX_DEG[lim]), int'(MIN_DEG[lim])));
      send_cmd(OP_SET, ID_W'(sid), ang);
    end else if (pick < 94) begin
      if ($urandom_range(4) == 0) ang = ANGLE_W'($urandom);
      else ang = ANGLE_W'(int'($urandom_range(80)) - 40);
      send_cmd(OP_TURN, ID_W'(sid), ang);
    end else begin
      send_cmd(OP_PARK, ID_W'($urandom), ANGLE_W'($urandom));
    end
  endtask

  task automatic run_phase(logic [PULSE_W-1:0] pmin, logic [PULSE_W-1:0] pmax,
                           logic [SMIN_W-1:0] smin, logic [SMAX_W-1:0] smax,
                           logic [PULSE_W-1:0] sdist, int idle, int stall);
    write_config(pmin, pmax, smin, smax, sdist);
    idle_pct  = idle;
    stall_pct = stall;
    repeat (ITEMS_PER_PHASE) random_cmd();
    drain();
  endtask

  initial begin
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= OP_TICK;
    req_ch.servo_id  <= '0;
    req_ch.angle_deg <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_PULSE_MIN;
    cfg_ch.data      <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: limits, dropped commands, clamping, reversal, park
    send_cmd(OP_TICK, 3'd0, 9'sd0);
    send_cmd(OP_SET, 3'd0, 9'sd178);
    send_cmd(OP_SET, 3'd1, 9'sd15);
    send_cmd(OP_SET, 3'd2, 9'sd181);
    send_cmd(OP_SET, 3'd5, -9'sd1);
    send_cmd(OP_SET, 3'd3, 9'sd255);
    send_cmd(OP_SET, 3'd6, 9'sd90);
    send_cmd(OP_TURN, 3'd4, -9'sd256);
    send_cmd(OP_TURN, 3'd3, 9'sd255);
    send_cmd(OP_TURN, 3'd7, 9'sd10);
    repeat (4) send_cmd(OP_TICK, 3'd0, 9'sd0);
    send_cmd(OP_SET, 3'd0, 9'sd2);
    repeat (2) send_cmd(OP_TICK, 3'd7, -9'sd1);
    send_cmd(OP_PARK, 3'd0, 9'sd0);
    repeat (6) send_cmd(OP_TICK, 3'd0, 9'sd0);
    drain();

    run_phase(12'd0, 12'd4095, 8'd1, 10'd1023, 12'd0, 84, 0);
    run_phase(12'd4095, 12'd0, 8'd255, 10'd1, 12'd4095, 0, 84);
    run_phase(PULSE_W'($urandom_range(4095)), PULSE_W'($urandom_range(4095)),
              SMIN_W'($urandom_range(255, 1)), SMAX_W'($urandom_range(1023, 1)),
              PULSE_W'($urandom_range(4095)), 9, 9);
    run_phase(12'd150, 12'd600, 8'd2, 10'd32, 12'd64, 0, 0);

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
